FILE: sv/rslu_pkg.sv
`timescale 1ns / 1ps

package rslu_pkg;

  // spotlight center register width and configuration indexes
  localparam int CENTER_BITS = 14;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 1'b1;

  // an axis offset above 160 already saturates the squared distance
  localparam int AXIS_BITS = 8;
  localparam logic [AXIS_BITS-1:0] AXIS_CLAMP = 8'd161;

  // squared distance, clamped to 160 squared
  localparam int D2_BITS = 15;
  localparam logic [D2_BITS-1:0] MAX_D2 = 15'd25600;

  // distance in Q8 and the full-scale dimming factor
  localparam int Q_BITS = 16;
  localparam logic [Q_BITS-1:0] FULL_SCALE = 16'd51200;

  // 51200 = 2^11 * 25
  localparam int SCALE_SHIFT = 11;
  localparam int SCALE_ODD = 25;

  // square root pipeline: 16 digit steps, 4 per stage
  localparam int RAD_BITS = 32;
  localparam int REM_BITS = Q_BITS + 2;
  localparam int SQ_STEPS_PER_STAGE = 4;
  localparam int SQ_STAGES = Q_BITS / SQ_STEPS_PER_STAGE;

  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [Q_BITS-1:0]   root;
    logic [RAD_BITS-1:0] rad;
  } sqrt_t;

endpackage

FILE: sv/radial_spotlight_luminance_unit.sv
`timescale 1ns / 1ps

// linear radial vignette: dims one pixel's luminance by 0.5 % per pixel of
// euclidean distance from a programmable spotlight centre, capped at 80 %
// from 160 pixels outwards
//
// input channel: a request is taken at a rising edge with start high and busy
// low; busy is always low, so a new pixel may be offered every clock
// result channel: out_valid marks lum_out for exactly one cycle; the receiver
// cannot hold results off and the pipeline never stalls
// configuration: cfg_we writes cfg_wdata into register cfg_index (0 centre x,
// 1 centre y, 14-bit two's complement) at the clock edge; write only while idle
//
// throughput: one pixel per clock, set by a 9-stage pipeline (abs/clamp,
// squares, four 4-digit square root stages, multiply, reciprocal multiply,
// correction); results leave in request order
// reset (synchronous, rst_n low): all valid bits clear, centre goes to (0, 0)

module radial_spotlight_luminance_unit #(
  parameter int COORD_BITS = 12,
  parameter int LUM_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // pixel requests
  input  logic                                  start,
  output logic                                  busy,
  input  logic [COORD_BITS-1:0]                 in_pixel_x,
  input  logic [COORD_BITS-1:0]                 in_pixel_y,
  input  logic [LUM_BITS-1:0]                   in_lum_in,
  // results
  output logic                                  out_valid,
  output logic [LUM_BITS-1:0]                   out_lum_out,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [rslu_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rslu_pkg::CENTER_BITS-1:0]      cfg_wdata
);

  // signed width that holds pixel minus centre exactly
  localparam int DW = ((COORD_BITS > rslu_pkg::CENTER_BITS) ?
                       COORD_BITS : rslu_pkg::CENTER_BITS) + 2;
  localparam int PW = LUM_BITS + rslu_pkg::Q_BITS;      // lum * factor
  localparam int XW = PW - rslu_pkg::SCALE_SHIFT;       // product >> 11
  localparam int RK = XW;                               // reciprocal shift
  localparam int MW = RK - 4;                           // 2^RK / 25 fits here
  localparam longint unsigned RECIP_L = (64'd1 << RK) / 64'd25;
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam int SQS = rslu_pkg::SQ_STAGES;

  // never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [rslu_pkg::CENTER_BITS-1:0] center_x_r;
  logic signed [rslu_pkg::CENTER_BITS-1:0] center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rslu_pkg::REG_CENTER_X: center_x_r <= cfg_wdata;
        rslu_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: axis offsets, absolute value, clamp at 161
  // ---------------------------------------------------------------------
  function automatic logic [rslu_pkg::AXIS_BITS-1:0] axis_offset(
    input logic [COORD_BITS-1:0]                 pix,
    input logic [rslu_pkg::CENTER_BITS-1:0]      ctr
  );
    logic signed [DW-1:0] pe;
    logic signed [DW-1:0] ce;
    logic signed [DW-1:0] d;
    logic [DW-1:0]        a;
    pe = signed'({{(DW-COORD_BITS){1'b0}}, pix});
    ce = signed'({{(DW-rslu_pkg::CENTER_BITS){ctr[rslu_pkg::CENTER_BITS-1]}}, ctr});
    d  = pe - ce;
    a  = d[DW-1] ? DW'(-d) : DW'(d);
    if (a > DW'(rslu_pkg::AXIS_CLAMP))
      return rslu_pkg::AXIS_CLAMP;
    return a[rslu_pkg::AXIS_BITS-1:0];
  endfunction

  logic                             s1_v_r;
  logic [rslu_pkg::AXIS_BITS-1:0]   ax_r, ay_r, ax_nxt, ay_nxt;
  logic [LUM_BITS-1:0]              s1_lum_r;

  assign ax_nxt = axis_offset(in_pixel_x, center_x_r);
  assign ay_nxt = axis_offset(in_pixel_y, center_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    s1_lum_r <= in_lum_in;
  end

  // ---------------------------------------------------------------------
  // stage 2: squared distance, clamped to 25600
  // ---------------------------------------------------------------------
  localparam int SQW = 2 * rslu_pkg::AXIS_BITS + 1;

  logic                             s2_v_r;
  logic [SQW-1:0]                   sum_sq;
  logic [rslu_pkg::D2_BITS-1:0]     d2_r, d2_nxt;
  logic [LUM_BITS-1:0]              s2_lum_r;

  assign sum_sq = SQW'(ax_r) * SQW'(ax_r) + SQW'(ay_r) * SQW'(ay_r);
  assign d2_nxt = (sum_sq > SQW'(rslu_pkg::MAX_D2)) ? rslu_pkg::MAX_D2 :
                  sum_sq[rslu_pkg::D2_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d2_r     <= d2_nxt;
    s2_lum_r <= s1_lum_r;
  end

  // ---------------------------------------------------------------------
  // stages 3-6: digit-by-digit square root of d2 * 65536, two radicand bits
  // per step, four steps per stage
  // ---------------------------------------------------------------------
  function automatic rslu_pkg::sqrt_t sqrt_step(input rslu_pkg::sqrt_t s);
    rslu_pkg::sqrt_t              o;
    logic [rslu_pkg::REM_BITS-1:0] rem_sh;
    logic [rslu_pkg::REM_BITS-1:0] trial;
    rem_sh = {s.rem[rslu_pkg::REM_BITS-3:0], s.rad[rslu_pkg::RAD_BITS-1 -: 2]};
    trial  = {s.root, 2'b01};
    o.rad  = {s.rad[rslu_pkg::RAD_BITS-3:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[rslu_pkg::Q_BITS-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[rslu_pkg::Q_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  rslu_pkg::sqrt_t      sq_r     [SQS];
  logic [LUM_BITS-1:0]  sq_lum_r [SQS];
  logic                 sq_v_r   [SQS];

  for (genvar g = 0; g < SQS; g++) begin : g_sq
    rslu_pkg::sqrt_t     src;
    rslu_pkg::sqrt_t     res_nxt;
    logic                src_v;
    logic [LUM_BITS-1:0] src_lum;

    if (g == 0) begin : g_first
      assign src.rem  = '0;
      assign src.root = '0;
      assign src.rad  = {1'b0, d2_r, {rslu_pkg::Q_BITS{1'b0}}};
      assign src_v    = s2_v_r;
      assign src_lum  = s2_lum_r;
    end else begin : g_rest
      assign src     = sq_r[g-1];
      assign src_v   = sq_v_r[g-1];
      assign src_lum = sq_lum_r[g-1];
    end

    always_comb begin
      res_nxt = src;
      for (int k = 0; k < rslu_pkg::SQ_STEPS_PER_STAGE; k++) begin
        res_nxt = sqrt_step(res_nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[g] <= 1'b0;
      end else begin
        sq_v_r[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      sq_r[g]     <= res_nxt;
      sq_lum_r[g] <= src_lum;
    end
  end

  // ---------------------------------------------------------------------
  // stage 7: lum * (51200 - q)
  // ---------------------------------------------------------------------
  logic                         s7_v_r;
  logic [rslu_pkg::Q_BITS-1:0]  factor;
  logic [PW-1:0]                prod_r;

  assign factor = rslu_pkg::FULL_SCALE - sq_r[SQS-1].root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else begin
      s7_v_r <= sq_v_r[SQS-1];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(sq_lum_r[SQS-1]) * PW'(factor);
  end

  // ---------------------------------------------------------------------
  // stage 8: divide by 2048 (shift), then multiply by reciprocal of 25
  // ---------------------------------------------------------------------
  logic              s8_v_r;
  logic [XW-1:0]     x_nxt, x_r;
  logic [XW+MW-1:0]  xm_r;

  assign x_nxt = prod_r[PW-1:rslu_pkg::SCALE_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    xm_r <= (XW+MW)'(x_nxt) * (XW+MW)'(RECIP);
  end

  // ---------------------------------------------------------------------
  // stage 9: estimate is low by at most one, one compare and step
  // ---------------------------------------------------------------------
  logic [LUM_BITS-1:0]  quot_est;
  logic [XW-1:0]        rem_est;
  logic [LUM_BITS-1:0]  lum_nxt;
  logic                 out_valid_r;
  logic [LUM_BITS-1:0]  lum_out_r;

  assign quot_est = xm_r[RK +: LUM_BITS];
  assign rem_est  = x_r - XW'(quot_est) * XW'(rslu_pkg::SCALE_ODD);
  assign lum_nxt  = (rem_est >= XW'(rslu_pkg::SCALE_ODD)) ? quot_est + 1'b1 : quot_est;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    lum_out_r <= lum_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_lum_out = lum_out_r;

`ifndef SYNTHESIS
  // clamped squared distance never passes 160 squared
  a_d2_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (d2_r <= rslu_pkg::MAX_D2))
    else $error("squared distance above clamp");

  // square root of at most 25600 * 65536 stays within 160 in Q8
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[SQS-1] |-> (sq_r[SQS-1].root <= 16'd40960))
    else $error("distance root out of range");

  // reciprocal estimate is never more than one below the quotient
  a_recip_error: assert property (@(posedge clk) disable iff (!rst_n)
    s8_v_r |-> (rem_est < XW'(2 * rslu_pkg::SCALE_ODD)))
    else $error("reciprocal estimate off by more than one");

  // every accepted request walks into the pipeline
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted request lost at entry");

  // a result only follows a valid item in the last stage
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s8_v_r))
    else $error("result without a request");
`endif

endmodule

FILE: tb/radial_spotlight_luminance_unit_test.sv
`timescale 1ns / 1ps

// expected dimmed luminance per pixel, with its own copy of the spotlight centre
class lum_scoreboard;
  logic signed [rslu_pkg::CENTER_BITS-1:0] centre_x;
  logic signed [rslu_pkg::CENTER_BITS-1:0] centre_y;
  logic [15:0] expected_lum[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    centre_x = '0;
    centre_y = '0;
    errors = 0;
    checked = 0;
  endfunction

  function void set_centre(logic signed [rslu_pkg::CENTER_BITS-1:0] cx,
                           logic signed [rslu_pkg::CENTER_BITS-1:0] cy);
    centre_x = cx;
    centre_y = cy;
  endfunction

  // floor of the square root, one result bit per step
  function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned one;
    root = 0;
    one = 64'd1 << 62;
    while (one > n) one = one >> 2;
    while (one != 0) begin
      if (n >= root + one) begin
        n = n - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    return root;
  endfunction

  function logic [15:0] dimmed_lum(logic [11:0] px, logic [11:0] py, logic [15:0] lum);
    longint dx;
    longint dy;
    longint unsigned d2;
    longint unsigned dist_q8;
    longint unsigned scaled;
    dx = longint'(px) - longint'(centre_x);
    dy = longint'(py) - longint'(centre_y);
    d2 = longint'(dx * dx + dy * dy);
    if (d2 > 25600) d2 = 25600;
    dist_q8 = int_sqrt(d2 << 16);
    if (dist_q8 > 51200) dist_q8 = 51200;
    scaled = (longint'(lum) * (51200 - dist_q8)) / 51200;
    return scaled[15:0];
  endfunction

  function void note_request(logic [11:0] px, logic [11:0] py, logic [15:0] lum);
    expected_lum.push_back(dimmed_lum(px, py, lum));
  endfunction

  function void check_result(logic [15:0] lum_out);
    logic [15:0] want;
    if (expected_lum.size() == 0) begin
      $error("lum_out: expected nothing, got %0d", lum_out);
      errors++;
      return;
    end
    want = expected_lum.pop_front();
    checked++;
    if (lum_out !== want) begin
      $error("lum_out: expected %0d, got %0d", want, lum_out);
      errors++;
    end
  endfunction

  function int pending();
    return expected_lum.size();
  endfunction

  function void flush_check();
    if (expected_lum.size() != 0) begin
      $error("lum_out: expected %0d more results, got none", expected_lum.size());
      errors++;
    end
  endfunction
endclass

module radial_spotlight_luminance_unit_test;

  localparam int COORD_W = 12;
  localparam int LUM_W = 16;
  // pipeline depth from the accepting edge to the result edge
  localparam int PIPE_LATENCY = 9;
  // the longest correct quiet stretch is well under this limit
  localparam int WATCHDOG_LIMIT = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 185;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [COORD_W-1:0] in_pixel_x = '0;
  logic [COORD_W-1:0] in_pixel_y = '0;
  logic [LUM_W-1:0] in_lum_in = '0;
  logic out_valid;
  logic [LUM_W-1:0] out_lum_out;
  logic cfg_we = 1'b0;
  logic [rslu_pkg::CFG_IDX_BITS-1:0] cfg_index = rslu_pkg::REG_CENTER_X;
  logic [rslu_pkg::CENTER_BITS-1:0] cfg_wdata = '0;

  lum_scoreboard sb;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned centres_used = 1;

  radial_spotlight_luminance_unit #(
    .COORD_BITS(COORD_W),
    .LUM_BITS(LUM_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .in_lum_in(in_lum_in),
    .out_valid(out_valid),
    .out_lum_out(out_lum_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // sample both channels at the edge: a request is taken with start high and
  // busy low, a result whenever out_valid is high
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_pixel_x, in_pixel_y, in_lum_in);
      if (out_valid) sb.check_result(out_lum_out);
    end
  end

  // watchdog: too many cycles with neither a request nor a result taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("radial_spotlight_luminance_unit_test: errors");
        $finish;
      end
    end
  end

  // one pixel request; the gap before it is random, except in bursts where
  // the sender offers a pixel on every clock
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic [LUM_W-1:0] lum);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_lum_in <= lum;
    do @(posedge clk); while (busy);
  endtask

  // let every outstanding request come back, then a few spare cycles so the
  // pipeline is empty before any register write
  task automatic drain_pipeline();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  // both centre registers, back to back, only while idle
  task automatic write_centre(input logic signed [rslu_pkg::CENTER_BITS-1:0] cx,
                              input logic signed [rslu_pkg::CENTER_BITS-1:0] cy);
    cfg_we <= 1'b1;
    cfg_index <= rslu_pkg::REG_CENTER_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_index <= rslu_pkg::REG_CENTER_Y;
    cfg_wdata <= cy;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_centre(cx, cy);
    centres_used++;
  endtask

  // coordinate within 200 pixels of the centre axis, pinned to the image
  function automatic logic [COORD_W-1:0] near_coord(int centre);
    int c;
    c = centre + int'($urandom_range(0, 400)) - 200;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c[COORD_W-1:0];
  endfunction

  function automatic logic [LUM_W-1:0] random_lum();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return LUM_W'($urandom);
    endcase
  endfunction

  initial begin
    int cx_set[RANDOM_PHASES];
    int cy_set[RANDOM_PHASES];
    sb = new();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, centre still at its reset value (0, 0)
    send_pixel(12'd0, 12'd0, 16'd0);         // on the centre, dark
    send_pixel(12'd0, 12'd0, 16'hffff);      // on the centre, full scale passes unchanged
    send_pixel(12'd3, 12'd4, 16'hffff);      // whole-pixel distance of 5
    send_pixel(12'd1, 12'd1, 16'hffff);      // irrational distance
    send_pixel(12'd160, 12'd0, 16'hffff);    // exactly at the cap radius
    send_pixel(12'd161, 12'd0, 16'hffff);    // just beyond the cap
    send_pixel(12'd96, 12'd128, 16'hffff);   // diagonal at exactly 160
    send_pixel(12'd0, 12'd159, 16'h0001);    // smallest non-zero luminance
    send_pixel(12'd4095, 12'd4095, 16'hffff); // far corner, capped
    send_pixel(12'haaa, 12'h555, 16'h8000);
    send_pixel(12'h555, 12'haaa, 16'h7fff);
    send_pixel(12'd113, 12'd113, 16'hffff);  // just above 159 diagonally
    drain_pipeline();

    // directed around a centre in the middle of the image
    write_centre(14'sd2048, 14'sd2048);
    send_pixel(12'd2048, 12'd2048, 16'hffff);
    send_pixel(12'd2208, 12'd2048, 16'hffff);
    send_pixel(12'd1888, 12'd2048, 16'hffff);
    send_pixel(12'd2048, 12'd1887, 16'hffff);
    send_pixel(12'd2144, 12'd2176, 16'hffff);
    send_pixel(12'd2047, 12'd2049, 16'hfffe);
    send_pixel(12'd2000, 12'd2100, 16'h1234);
    send_pixel(12'd0, 12'd4095, 16'hffff);
    drain_pipeline();

    // random phases: reset centre, mid image, three of the four register extremes,
    // an image edge and two random centres
    cx_set = '{0, 2048, -8192, 8191, -8192, 4095, 0, 0};
    cy_set = '{0, 1024, -8192, 8191, 8191, 0, 0, 0};
    cx_set[6] = $urandom_range(0, 4095);
    cy_set[6] = $urandom_range(0, 4095);
    cx_set[7] = int'($urandom_range(0, 16383)) - 8192;
    cy_set[7] = int'($urandom_range(0, 16383)) - 8192;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_centre(cx_set[p][rslu_pkg::CENTER_BITS-1:0],
                   cy_set[p][rslu_pkg::CENTER_BITS-1:0]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly pixels within reach of the spotlight, the rest anywhere
        if ($urandom_range(0, 9) < 7)
          send_pixel(near_coord(cx_set[p]), near_coord(cy_set[p]), random_lum());
        else
          send_pixel(COORD_W'($urandom), COORD_W'($urandom), random_lum());
      end
      drain_pipeline();
    end

    sb.flush_check();
    $display("checked %0d pixel results across %0d spotlight centres",
             sb.checked, centres_used);
    if (sb.errors == 0)
      $display("radial_spotlight_luminance_unit_test: clean");
    else
      $display("radial_spotlight_luminance_unit_test: errors");
    $finish;
  end
endmodule
